// ----- rtl/ccs_pkg.sv -----
package ccs_pkg;

   localparam logic [7:0] ChSlash = 8'h2F;
   localparam logic [7:0] ChQuote = 8'h22;
   localparam logic [7:0] ChStar  = 8'h2A;
   localparam logic [7:0] ChNl    = 8'h0A;
   localparam logic [7:0] ChBsl   = 8'h5C;

   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       text_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_present;
      logic       out_last;
   } rsp_type;

   // One classified request: up to two output bytes, or an empty end marker.
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       two;
      logic       present;
      logic       last;
   } act_type;

endpackage

// ----- rtl/ccs_front.sv -----
module ccs_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ccs_pkg::req_type req,
   input  logic             q_full,
   output logic             push,
   output ccs_pkg::act_type push_act
);

   typedef enum logic [2:0] {
      MPlain = 3'd0,
      MSlash = 3'd1,
      MLine  = 3'd2,
      MBlock = 3'd3,
      MStar  = 3'd4,
      MStr   = 3'd5,
      MEsc   = 3'd6
   } mode_type;

   mode_type   mode_ff;
   mode_type   mode_in;
   mode_type   next_mode;
   logic [1:0] cnt;
   logic [7:0] b0;
   logic [7:0] b1;
   logic [7:0] c;
   logic       accept;

   assign c         = req.in_byte;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      next_mode = mode_ff;
      cnt       = 2'd0;
      b0        = c;
      b1        = c;
      case (mode_ff)
         MSlash: begin
            if (c == ccs_pkg::ChSlash) begin
               next_mode = MLine;
            end else if (c == ccs_pkg::ChStar) begin
               next_mode = MBlock;
            end else begin
               // lone slash: pass it along with the byte after it
               b0        = ccs_pkg::ChSlash;
               cnt       = 2'd2;
               next_mode = (c == ccs_pkg::ChQuote) ? MStr : MPlain;
            end
         end
         MLine: begin
            if (c == ccs_pkg::ChNl) begin
               cnt       = 2'd1;
               next_mode = MPlain;
            end
         end
         MBlock: begin
            if (c == ccs_pkg::ChStar) begin
               next_mode = MStar;
            end
         end
         MStar: begin
            if (c == ccs_pkg::ChSlash) begin
               next_mode = MPlain;
            end else if (c != ccs_pkg::ChStar) begin
               next_mode = MBlock;
            end
         end
         MStr: begin
            cnt = 2'd1;
            if (c == ccs_pkg::ChQuote) begin
               next_mode = MPlain;
            end else if (c == ccs_pkg::ChBsl) begin
               next_mode = MEsc;
            end
         end
         MEsc: begin
            cnt       = 2'd1;
            next_mode = MStr;
         end
         default: begin
            if (c == ccs_pkg::ChSlash) begin
               next_mode = MSlash;
            end else begin
               cnt       = 2'd1;
               next_mode = (c == ccs_pkg::ChQuote) ? MStr : MPlain;
            end
         end
      endcase
      // flush a pending slash at end of text
      if (req.text_end && next_mode == MSlash) begin
         b0  = ccs_pkg::ChSlash;
         cnt = 2'd1;
      end
   end

   always_comb begin
      push_act.byte0   = b0;
      push_act.byte1   = b1;
      push_act.two     = (cnt == 2'd2);
      push_act.present = (cnt != 2'd0);
      push_act.last    = req.text_end;
      push             = accept && ((cnt != 2'd0) || req.text_end);
      mode_in          = mode_ff;
      if (accept) begin
         mode_in = req.text_end ? MPlain : next_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MPlain;
      end else begin
         mode_ff <= mode_in;
      end
   end

endmodule

// ----- rtl/ccs_queue.sv -----
module ccs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ccs_pkg::act_type push_act,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output ccs_pkg::act_type head_act
);

   ccs_pkg::act_type               q_ff [ccs_pkg::QDepth];
   logic [ccs_pkg::QPtrW-1:0]      wr_ptr_ff;
   logic [ccs_pkg::QPtrW-1:0]      wr_ptr_in;
   logic [ccs_pkg::QPtrW-1:0]      rd_ptr_ff;
   logic [ccs_pkg::QPtrW-1:0]      rd_ptr_in;
   logic [ccs_pkg::QCntW-1:0]      count_ff;
   logic [ccs_pkg::QCntW-1:0]      count_in;

   assign full       = (count_ff == ccs_pkg::QCntW'(ccs_pkg::QDepth));
   assign head_valid = (count_ff != '0);
   assign head_act   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_act;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/ccs_back.sv -----
module ccs_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  ccs_pkg::act_type head_act,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ccs_pkg::rsp_type rsp
);

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   ccs_pkg::rsp_type rsp_ff;
   ccs_pkg::rsp_type rsp_in;
   logic             sec_valid_ff;
   logic             sec_valid_in;
   logic [7:0]       sec_byte_ff;
   logic [7:0]       sec_byte_in;
   logic             sec_last_ff;
   logic             sec_last_in;
   logic             load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign load      = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      sec_valid_in = sec_valid_ff;
      sec_byte_in  = sec_byte_ff;
      sec_last_in  = sec_last_ff;
      pop          = 1'b0;
      if (load) begin
         if (sec_valid_ff) begin
            // second byte of a lone-slash pair goes out before the next request
            rsp_valid_in        = 1'b1;
            rsp_in.out_byte     = sec_byte_ff;
            rsp_in.byte_present = 1'b1;
            rsp_in.out_last     = sec_last_ff;
            sec_valid_in        = 1'b0;
         end else if (head_valid) begin
            pop                 = 1'b1;
            rsp_valid_in        = 1'b1;
            rsp_in.out_byte     = head_act.present ? head_act.byte0 : 8'h00;
            rsp_in.byte_present = head_act.present;
            rsp_in.out_last     = head_act.last && !head_act.two;
            sec_valid_in        = head_act.two;
            sec_byte_in         = head_act.byte1;
            sec_last_in         = head_act.last;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      sec_byte_ff <= sec_byte_in;
      sec_last_ff <= sec_last_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
   end

endmodule

// ----- rtl/c_comment_stripper_core.sv -----
// Channel  Dir  Handshake             Payload
// req      in   req_valid/req_ready   req.in_byte, req.text_end
// rsp      out  rsp_valid/rsp_ready   rsp.out_byte, rsp.byte_present, rsp.out_last
//
// Takes one request per cycle while the queue is not full; a request yields at
// most one response, but the byte after a lone slash yields two with the slash.
// The combinational lexer feeds a 4-entry queue, then the output register.
// req_ready drops only when the queue is full; rsp stalls back up into it.
// Reset returns the lexer to plain code and empties queue and output register.
module c_comment_stripper_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ccs_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ccs_pkg::rsp_type rsp
);

   logic             push;
   ccs_pkg::act_type push_act;
   logic             q_full;
   logic             pop;
   logic             head_valid;
   ccs_pkg::act_type head_act;

   ccs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .q_full    (q_full),
      .push      (push),
      .push_act  (push_act)
   );

   ccs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_act   (push_act),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_act   (head_act)
   );

   ccs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_act   (head_act),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

endmodule
